// ===== design/bdec_pkg.sv =====
// Shared types and codes for the boolean arithmetic decoder.
// Holds the item/result payload structs and the controller/datapath command and status structs.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package bdec_pkg;

	// Field widths of one input item and one result item
	localparam int OP_W       = 3;
	localparam int BYTE_W     = 8;
	localparam int PROB_W     = 8;
	localparam int BITCNT_W   = 6;
	localparam int DECODED_W  = 33;
	localparam int CONSUMED_W = 24;
	localparam int OVRCNT_W   = 16;
	localparam int ACC_W      = 32;

	// Operation codes
	localparam logic [OP_W-1:0] OP_PUSH    = 3'd0;
	localparam logic [OP_W-1:0] OP_START   = 3'd1;
	localparam logic [OP_W-1:0] OP_BOOL    = 3'd2;
	localparam logic [OP_W-1:0] OP_LITERAL = 3'd3;
	localparam logic [OP_W-1:0] OP_SIGNED  = 3'd4;

	// How the decoded field of a result is formed
	localparam logic [1:0] OUTSEL_BIT      = 2'd0;
	localparam logic [1:0] OUTSEL_UNSIGNED = 2'd1;
	localparam logic [1:0] OUTSEL_SIGNED   = 2'd2;

	typedef struct packed {
		logic [OP_W-1:0]     op;
		logic [BYTE_W-1:0]   byte_in;
		logic [PROB_W-1:0]   probability;
		logic [BITCNT_W-1:0] bit_count;
	} item_t;

	typedef struct packed {
		logic signed [DECODED_W-1:0] decoded;
		logic                        overrun_seen;
		logic [CONSUMED_W-1:0]       consumed_bytes;
		logic [OVRCNT_W-1:0]         overrun_bytes;
	} result_t;

	// Controller to datapath
	typedef struct packed {
		logic       capture;   // latch item probability on transfer
		logic       push;      // write byte into queue
		logic       start_a;   // restart coder, take first byte
		logic       start_b;   // take second byte
		logic       split_en;  // compute split from range and probability
		logic       use_prob;  // use item probability, else one half
		logic       cmp_en;    // compare window against split, pick bit
		logic       shift_en;  // normalize range, refill window
		logic       acc_clear; // clear literal accumulator
		logic       acc_shift; // shift decoded bit into accumulator
		logic       load_out;  // load result register
		logic [1:0] out_sel;
	} cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic acc_next_nz; // accumulator nonzero once current bit goes in
	} sts_t;

endpackage

`default_nettype wire

// ===== design/boolean_arithmetic_decoder.sv =====
// Boolean arithmetic (range) decoder with a front byte queue: top level.
// Joins the controller bdec_ctrl and the datapath bdec_datapath.
// Depends on bdec_pkg, bdec_ctrl, bdec_datapath.
//
// Compressed bytes are written with push items into a queue of QUEUE_DEPTH bytes (a full
// queue drops the byte); a start item restarts the coder and loads up to two bytes.
// A push is handled in the cycle it transfers, so pushes can stream one per clock while
// the controller is idle; a start takes the first byte and then the second byte;
// a bool decode is one pass through the three-step bool unit (multiply for the split,
// compare and subtract, normalize and refill) followed by loading the result; a literal
// decode of N bits runs the unit once per bit, and a signed decode runs it once more for
// the sign bit when the magnitude is nonzero. A waiting result does not block the input:
// the next item transfers while the result register is full, and only a decode that
// finishes before that result leaves stalls. The queue memory is not cleared at reset
// and needs no start-up time.
`timescale 1ns / 1ps
`default_nettype none

module boolean_arithmetic_decoder import bdec_pkg::*; #(
	parameter int QUEUE_DEPTH      = 16,
	parameter int MAX_LITERAL_BITS = 32
) (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    item_valid,
	output logic         item_ready,
	input  wire item_t   item,
	output logic         result_valid,
	input  wire logic    result_ready,
	output result_t      result
);

	cmd_t cmd;
	sts_t sts;

	bdec_ctrl #(
		.MAX_LITERAL_BITS (MAX_LITERAL_BITS)
	) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.cmd          (cmd),
		.sts          (sts)
	);

	bdec_datapath #(
		.QUEUE_DEPTH (QUEUE_DEPTH)
	) u_datapath (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item),
		.cmd    (cmd),
		.sts    (sts),
		.result (result)
	);

endmodule

`default_nettype wire

// ===== design/bdec_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// Old data is returned on a read of the address written in the same cycle.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module bdec_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data <= mem_q[rd_addr];
	end

endmodule

`default_nettype wire

// ===== design/bdec_datapath.sv =====
// Datapath of the boolean arithmetic decoder: byte queue, range/window arithmetic,
// literal accumulator, counters and result register.
// Depends on bdec_pkg and bdec_ram.
`timescale 1ns / 1ps
`default_nettype none

module bdec_datapath import bdec_pkg::*; #(
	parameter int QUEUE_DEPTH = 16
) (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire item_t   item,
	input  wire cmd_t    cmd,
	output sts_t         sts,
	output result_t      result
);

	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	localparam logic [7:0]        RANGE_START = 8'd255;
	localparam logic [7:0]        PROB_HALF   = 8'd128;
	localparam logic signed [4:0] FILL_START  = -5'sd8;
	localparam logic signed [4:0] BYTE_BITS   = 5'sd8;

	// Leading zeros of a nonzero range below 128; zero range is left alone
	function automatic logic [2:0] norm_shift(input logic [7:0] r);
		logic [2:0] s;
		s = '0;
		for (int i = 0; i < 8; i++) begin
			if (r[i]) begin
				s = 3'(7 - i);
			end
		end
		return s;
	endfunction

	function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	// Queue state
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [PTR_W-1:0] rd_ptr_d;
	logic [CNT_W-1:0] count_q;
	logic             queue_full;
	logic             queue_empty;
	logic             wr_en;
	logic             pop;
	logic [7:0]       head_byte;

	// Coder state
	logic [7:0]        prob_q;
	logic [7:0]        split_q;
	logic              bit_q;
	logic [7:0]        range_q;
	logic [31:0]       value_q;
	logic signed [4:0] fill_q;
	logic [CONSUMED_W-1:0] consumed_q;
	logic              ovr_flag_q;
	logic [OVRCNT_W-1:0] ovr_cnt_q;
	logic [ACC_W-1:0]  acc_q;
	result_t           result_q;

	// Arithmetic
	logic [7:0]        prob_sel;
	logic [7:0]        range_m1;
	logic [15:0]       prod;
	logic [31:0]       big;
	logic [31:0]       diff;
	logic              ge;
	logic [2:0]        shift_amt;
	logic signed [4:0] fill_sum;
	logic              need_byte;
	logic [31:0]       value_sh;
	logic [31:0]       byte_sh;
	logic [ACC_W-1:0]  acc_next;
	logic [DECODED_W-1:0] acc_ext;
	logic [DECODED_W-1:0] decoded_d;

	// Byte queue storage
	bdec_ram #(
		.WIDTH (BYTE_W),
		.DEPTH (QUEUE_DEPTH)
	) u_queue_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_ptr_q),
		.wr_data (item.byte_in),
		.rd_addr (rd_ptr_d),
		.rd_data (head_byte)
	);

	// Queue control; read address looks ahead so the head byte is always ready
	assign queue_full  = (count_q == CNT_W'(QUEUE_DEPTH));
	assign queue_empty = (count_q == '0);
	assign wr_en       = cmd.push && !queue_full;

	// Split, compare and normalize arithmetic
	assign prob_sel  = cmd.use_prob ? prob_q : PROB_HALF;
	assign range_m1  = range_q - 8'd1;
	assign prod      = 16'(range_m1) * 16'(prob_sel);
	assign big       = {16'b0, split_q, 8'b0};
	assign ge        = (value_q >= big);
	assign diff      = value_q - big;
	assign shift_amt = norm_shift(range_q);
	assign fill_sum  = fill_q + signed'({2'b00, shift_amt});
	assign need_byte = cmd.shift_en && !fill_sum[4];
	assign value_sh  = value_q << shift_amt;
	assign byte_sh   = 32'(head_byte) << fill_sum[2:0];

	assign pop      = !queue_empty && (cmd.start_a || cmd.start_b || need_byte);
	assign rd_ptr_d = pop ? ptr_inc(rd_ptr_q) : rd_ptr_q;

	// Accumulator and result formatting
	assign acc_next        = {acc_q[ACC_W-2:0], bit_q};
	assign sts.acc_next_nz = (acc_next != '0);
	assign acc_ext         = {1'b0, acc_q};

	always_comb begin
		case (cmd.out_sel)
			OUTSEL_BIT:      decoded_d = {{(DECODED_W-1){1'b0}}, bit_q};
			OUTSEL_UNSIGNED: decoded_d = acc_ext;
			OUTSEL_SIGNED:   decoded_d = bit_q ? ('0 - acc_ext) : acc_ext;
			default:         decoded_d = acc_ext;
		endcase
	end

	// Queue pointers and fill
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			rd_ptr_q <= rd_ptr_d;
			if (wr_en) begin
				wr_ptr_q <= ptr_inc(wr_ptr_q);
				count_q  <= count_q + 1'b1;
			end else if (pop) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Coder range, window, fill position and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			range_q    <= RANGE_START;
			value_q    <= '0;
			fill_q     <= FILL_START;
			consumed_q <= '0;
			ovr_flag_q <= 1'b0;
			ovr_cnt_q  <= '0;
		end else if (cmd.start_a) begin
			range_q    <= RANGE_START;
			value_q    <= queue_empty ? '0 : {16'b0, head_byte, 8'b0};
			fill_q     <= FILL_START;
			consumed_q <= queue_empty ? '0 : CONSUMED_W'(1);
			ovr_flag_q <= 1'b0;
			ovr_cnt_q  <= '0;
		end else if (cmd.start_b) begin
			if (!queue_empty) begin
				value_q <= value_q | {24'b0, head_byte};
				if (!(&consumed_q)) begin
					consumed_q <= consumed_q + 1'b1;
				end
			end
		end else if (cmd.cmp_en) begin
			if (ge) begin
				value_q <= diff;
				range_q <= range_q - split_q;
			end else begin
				range_q <= split_q;
			end
		end else if (cmd.shift_en) begin
			range_q <= range_q << shift_amt;
			if (need_byte) begin
				fill_q <= fill_sum - BYTE_BITS;
				if (!queue_empty) begin
					value_q <= value_sh | byte_sh;
					if (!(&consumed_q)) begin
						consumed_q <= consumed_q + 1'b1;
					end
				end else begin
					// end of data: zeros come in
					value_q    <= value_sh;
					ovr_flag_q <= 1'b1;
					if (!(&ovr_cnt_q)) begin
						ovr_cnt_q <= ovr_cnt_q + 1'b1;
					end
				end
			end else begin
				fill_q  <= fill_sum;
				value_q <= value_sh;
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			prob_q <= item.probability;
		end
		if (cmd.split_en) begin
			split_q <= prod[15:8] + 8'd1;
		end
		if (cmd.cmp_en) begin
			bit_q <= ge;
		end
		if (cmd.acc_clear) begin
			acc_q <= '0;
		end else if (cmd.acc_shift) begin
			acc_q <= acc_next;
		end
		if (cmd.load_out) begin
			result_q.decoded        <= decoded_d;
			result_q.overrun_seen   <= ovr_flag_q;
			result_q.consumed_bytes <= consumed_q;
			result_q.overrun_bytes  <= ovr_cnt_q;
		end
	end

	assign result = result_q;

`ifndef SYNTHESIS
	// Queue never holds more than its depth
	assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(QUEUE_DEPTH))
		else $error("byte queue count exceeds depth");

	// After refill the window always waits for more bits
	assert property (@(posedge clk) disable iff (!arst_n)
		$past(cmd.shift_en) |-> fill_q[4])
		else $error("fill position not negative after refill");

	// Normalized range has its top bit set, unless it is zero
	assert property (@(posedge clk) disable iff (!arst_n)
		$past(cmd.shift_en) |-> (range_q[7] || range_q == 8'd0))
		else $error("range not normalized");
`endif

endmodule

`default_nettype wire

// ===== design/bdec_ctrl.sv =====
// Controller of the boolean arithmetic decoder: sequences push, start and
// bool/literal/signed decodes, and owns the handshakes.
// Depends on bdec_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bdec_ctrl import bdec_pkg::*; #(
	parameter int MAX_LITERAL_BITS = 32
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  item_valid,
	output logic       item_ready,
	input  wire item_t item,
	output logic       result_valid,
	input  wire logic  result_ready,
	output cmd_t       cmd,
	input  wire sts_t  sts
);

	localparam logic [2:0] ST_IDLE    = 3'd0;
	localparam logic [2:0] ST_START_A = 3'd1;
	localparam logic [2:0] ST_START_B = 3'd2;
	localparam logic [2:0] ST_SPLIT   = 3'd3;
	localparam logic [2:0] ST_CMP     = 3'd4;
	localparam logic [2:0] ST_SHIFT   = 3'd5;
	localparam logic [2:0] ST_RESULT  = 3'd6;

	localparam int SGN_LIMIT = (MAX_LITERAL_BITS < 31) ? MAX_LITERAL_BITS : 31;
	localparam logic [BITCNT_W-1:0] LIT_CAP = BITCNT_W'(MAX_LITERAL_BITS);
	localparam logic [BITCNT_W-1:0] SGN_CAP = BITCNT_W'(SGN_LIMIT);

	logic [2:0]          state_q, state_d;
	logic [OP_W-1:0]     mode_q, mode_d;
	logic                sign_phase_q, sign_phase_d;
	logic [BITCNT_W-1:0] bits_q, bits_d;
	logic [1:0]          out_sel_q, out_sel_d;
	logic                out_valid_q;
	logic                accept;
	logic [BITCNT_W-1:0] cap;
	logic [BITCNT_W-1:0] bits_eff;

	assign item_ready   = (state_q == ST_IDLE);
	assign accept       = item_valid && item_ready;
	assign result_valid = out_valid_q;

	// Clamp the requested bit count
	assign cap      = (item.op == OP_SIGNED) ? SGN_CAP : LIT_CAP;
	assign bits_eff = (item.bit_count > cap) ? cap : item.bit_count;

	// Next state and datapath commands
	always_comb begin
		cmd          = '0;
		state_d      = state_q;
		mode_d       = mode_q;
		sign_phase_d = sign_phase_q;
		bits_d       = bits_q;
		out_sel_d    = out_sel_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					cmd.capture = 1'b1;
					case (item.op)
						OP_PUSH: begin
							cmd.push = 1'b1;
						end
						OP_START: begin
							state_d = ST_START_A;
						end
						OP_BOOL: begin
							mode_d       = OP_BOOL;
							sign_phase_d = 1'b0;
							out_sel_d    = OUTSEL_BIT;
							state_d      = ST_SPLIT;
						end
						OP_LITERAL, OP_SIGNED: begin
							mode_d        = item.op;
							sign_phase_d  = 1'b0;
							bits_d        = bits_eff;
							cmd.acc_clear = 1'b1;
							out_sel_d     = OUTSEL_UNSIGNED;
							state_d       = (bits_eff == '0) ? ST_RESULT : ST_SPLIT;
						end
						default: begin
							state_d = ST_IDLE;
						end
					endcase
				end
			end
			ST_START_A: begin
				cmd.start_a = 1'b1;
				state_d     = ST_START_B;
			end
			ST_START_B: begin
				cmd.start_b = 1'b1;
				state_d     = ST_IDLE;
			end
			ST_SPLIT: begin
				cmd.split_en = 1'b1;
				cmd.use_prob = (mode_q == OP_BOOL);
				state_d      = ST_CMP;
			end
			ST_CMP: begin
				cmd.cmp_en = 1'b1;
				state_d    = ST_SHIFT;
			end
			ST_SHIFT: begin
				cmd.shift_en = 1'b1;
				if (mode_q == OP_BOOL) begin
					state_d = ST_RESULT;
				end else if (sign_phase_q) begin
					out_sel_d = OUTSEL_SIGNED;
					state_d   = ST_RESULT;
				end else begin
					// magnitude bit, MSB first
					cmd.acc_shift = 1'b1;
					bits_d        = bits_q - 1'b1;
					if (bits_q == BITCNT_W'(1)) begin
						if (mode_q == OP_SIGNED && sts.acc_next_nz) begin
							sign_phase_d = 1'b1;
							state_d      = ST_SPLIT;
						end else begin
							state_d = ST_RESULT;
						end
					end else begin
						state_d = ST_SPLIT;
					end
				end
			end
			ST_RESULT: begin
				cmd.out_sel = out_sel_q;
				if (!out_valid_q || result_ready) begin
					cmd.load_out = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			mode_q       <= OP_PUSH;
			sign_phase_q <= 1'b0;
			bits_q       <= '0;
			out_sel_q    <= OUTSEL_BIT;
			out_valid_q  <= 1'b0;
		end else begin
			state_q      <= state_d;
			mode_q       <= mode_d;
			sign_phase_q <= sign_phase_d;
			bits_q       <= bits_d;
			out_sel_q    <= out_sel_d;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (result_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

`ifndef SYNTHESIS
	// Result register is never overwritten while a transfer is pending
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> (!out_valid_q || result_ready))
		else $error("result overwritten before transfer");

	// Compare always follows split
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CMP) |-> ($past(state_q) == ST_SPLIT))
		else $error("compare step without split");

	// Sign bit is read only in signed mode
	assert property (@(posedge clk) disable iff (!arst_n)
		(sign_phase_q && state_q != ST_IDLE) |-> (mode_q == OP_SIGNED))
		else $error("sign phase outside signed decode");
`endif

endmodule

`default_nettype wire

// ===== verif/tb.sv =====
// Self-checking testbench for boolean_arithmetic_decoder: byte pushes, stream starts and
// bool/literal/signed decodes, with random idling on both handshakes.
// Depends on bdec_pkg and the boolean_arithmetic_decoder RTL.
`timescale 1ns / 1ps

module tb;
	import bdec_pkg::*;

	localparam int QDEPTH      = 16;
	localparam int MAXBITS     = 32;
	localparam int ITEM_GOAL   = 1100;
	localparam int DRAIN_WAIT  = 20000;  // cycles allowed for outstanding decodes
	localparam int SETTLE      = 150;    // longest decode plus margin
	localparam int SIGNED_BITS = 31;
	localparam logic [7:0] RANGE_INIT = 8'd255;
	localparam logic [7:0] HALF_PROB  = 8'd128;
	localparam logic [7:0] PROB_MAX   = 8'd255;
	localparam logic [OP_W-1:0] OP_LAST = 3'd7;

	typedef struct {
		item_t it;
		bit    hold;   // present only once every decode result is back
	} stim_t;

	logic    clk          = 1'b0;
	logic    arst_n       = 1'b0;
	logic    item_valid   = 1'b0;
	logic    item_ready;
	item_t   item         = '0;
	logic    result_valid;
	logic    result_ready = 1'b0;
	result_t result;

	stim_t   stim_q[$];
	result_t due_results[$];
	int      n_total;
	int      items_sent;
	int      n_real;
	int      errors;

	// Coder state as the block should hold it
	logic [7:0]  cod_range  = RANGE_INIT;
	logic [31:0] cod_window = '0;
	int          cod_fill   = -8;
	logic [7:0]  cod_queue[$];
	logic [23:0] cod_used   = '0;
	logic        cod_ovf    = 1'b0;
	logic [15:0] cod_ovcnt  = '0;

	boolean_arithmetic_decoder #(
		.QUEUE_DEPTH     (QDEPTH),
		.MAX_LITERAL_BITS(MAXBITS)
	) DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.item_valid  (item_valid),
		.item_ready  (item_ready),
		.item        (item),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.result      (result)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	task automatic report(input string msg);
		errors++;
		$display("ERROR @%0t: %s", $time, msg);
	endtask

	// Take the oldest queued byte; counts toward consumed bytes
	function automatic bit pull_byte(output logic [7:0] b);
		b = '0;
		if (cod_queue.size() == 0)
			return 1'b0;
		b = cod_queue.pop_front();
		if (cod_used != '1)
			cod_used++;
		return 1'b1;
	endfunction

	// Top up the window; an empty queue shifts in zeros and marks overrun
	function automatic void refill_window();
		logic [7:0] b;
		while (cod_fill >= 0) begin
			if (pull_byte(b)) begin
				cod_window |= 32'(b) << (cod_fill & 31);
			end else begin
				cod_ovf = 1'b1;
				if (cod_ovcnt != '1)
					cod_ovcnt++;
			end
			cod_fill -= 8;
		end
	endfunction

	// One bool decode: split, compare, normalize, refill
	function automatic logic decode_bit(input logic [7:0] prob);
		logic [31:0] rng;
		logic [31:0] split;
		logic [31:0] big;
		int          sh;
		logic        bitv;
		rng   = 32'(cod_range);
		split = 32'd1 + ((((rng - 32'd1) & 32'hFF) * 32'(prob)) >> 8);
		big   = split << 8;
		sh    = 0;
		if (cod_window >= big) begin
			rng        = (rng - split) & 32'hFF;
			cod_window = cod_window - big;
			bitv       = 1'b1;
		end else begin
			rng  = split & 32'hFF;
			bitv = 1'b0;
		end
		while (rng != 0 && rng < 128) begin
			rng = rng << 1;
			sh++;
		end
		cod_range  = rng[7:0];
		cod_window = cod_window << sh;
		cod_fill  += sh;
		refill_window();
		return bitv;
	endfunction

	// n bits at one half, MSB first
	function automatic logic [31:0] decode_bits(input int n);
		logic [31:0] acc;
		acc = '0;
		for (int i = n - 1; i >= 0; i--)
			acc |= 32'(decode_bit(HALF_PROB)) << i;
		return acc;
	endfunction

	// Apply one accepted item to the coder state; returns 1 with the result for a decode
	function automatic bit step_coder(input item_t it, output result_t r);
		int          n;
		logic [31:0] mag;
		logic [7:0]  b;
		r = '0;
		case (it.op)
			OP_PUSH: begin
				if (cod_queue.size() < QDEPTH)
					cod_queue.push_back(it.byte_in);
				return 1'b0;
			end
			OP_START: begin
				cod_range  = RANGE_INIT;
				cod_window = '0;
				cod_used   = '0;
				cod_ovf    = 1'b0;
				cod_ovcnt  = '0;
				if (pull_byte(b)) begin
					cod_window |= 32'(b) << 8;
					if (pull_byte(b))
						cod_window |= 32'(b);
				end
				cod_fill = -8;
				return 1'b0;
			end
			OP_BOOL: r.decoded = 33'(decode_bit(it.probability));
			OP_LITERAL: begin
				n = (it.bit_count > MAXBITS) ? MAXBITS : int'(it.bit_count);
				r.decoded = {1'b0, decode_bits(n)};
			end
			OP_SIGNED: begin
				n = (it.bit_count > SIGNED_BITS) ? SIGNED_BITS : int'(it.bit_count);
				if (n > MAXBITS)
					n = MAXBITS;
				mag = decode_bits(n);
				if (mag == 0)
					r.decoded = '0;
				else if (decode_bit(HALF_PROB))
					r.decoded = -{1'b0, mag};
				else
					r.decoded = {1'b0, mag};
			end
			default: return 1'b0;
		endcase
		r.overrun_seen   = cod_ovf;
		r.consumed_bytes = cod_used;
		r.overrun_bytes  = cod_ovcnt;
		return 1'b1;
	endfunction

	// Idle percentage for the sender or receiver in the current phase of the run
	function automatic int idle_pct(input bit rx_side);
		int stage;
		stage = (n_total == 0) ? 0 : items_sent * 3 / n_total;
		case (stage)
			0: return rx_side ? 85 : 36;
			1: return rx_side ? 36 : 85;
			default: return 0;
		endcase
	endfunction

	function automatic void add_item(input logic [OP_W-1:0] op, input logic [7:0] b,
			input logic [7:0] prob, input logic [5:0] cnt, input bit hold);
		stim_t s;
		s.it.op          = op;
		s.it.byte_in     = b;
		s.it.probability = prob;
		s.it.bit_count   = cnt;
		s.hold           = hold;
		stim_q.push_back(s);
		if (op <= OP_SIGNED)
			n_real++;
	endfunction

	function automatic logic [5:0] rand_count();
		return ($urandom_range(9) == 0) ? 6'($urandom_range(63)) : 6'($urandom_range(8));
	endfunction

	function automatic logic [7:0] rand_prob();
		case ($urandom_range(9))
			0: return '0;
			1: return PROB_MAX;
			default: return 8'($urandom_range(255));
		endcase
	endfunction

	// One stream: preload, start, then decodes mixed with pushes and a little noise
	function automatic void add_stream();
		int k;
		int m;
		int push_pct;
		int r;
		k = $urandom_range(18);
		for (int i = 0; i < k; i++)
			add_item(OP_PUSH, 8'($urandom_range(255)), 8'($urandom), 6'($urandom), 1'b0);
		add_item(OP_START, 8'($urandom), 8'($urandom), 6'($urandom), $urandom_range(19) == 0);
		push_pct = $urandom_range(10, 60);
		m = $urandom_range(5, 40);
		for (int i = 0; i < m; i++) begin
			r = $urandom_range(99);
			if (r < 2) begin
				add_item(OP_W'(OP_SIGNED + $urandom_range(1, 3)), 8'($urandom), 8'($urandom),
					6'($urandom), 1'b0);
			end else if (r < 4) begin
				add_item(OP_START, 8'($urandom), 8'($urandom), 6'($urandom), 1'b0);
			end else if ($urandom_range(99) < push_pct) begin
				add_item(OP_PUSH, 8'($urandom_range(255)), 8'($urandom), 6'($urandom),
					$urandom_range(99) == 0);
			end else begin
				case ($urandom_range(2))
					0: add_item(OP_BOOL, 8'($urandom), rand_prob(), 6'($urandom), 1'b0);
					1: add_item(OP_LITERAL, 8'($urandom), 8'($urandom), rand_count(),
						$urandom_range(99) == 0);
					default: add_item(OP_SIGNED, 8'($urandom), 8'($urandom), rand_count(),
						1'b0);
				endcase
			end
		end
	endfunction

	// Driver: present the next queued item, hold it until the transfer
	always @(posedge clk or negedge arst_n) begin
		stim_t   s;
		result_t r;
		bit      waiting;
		if (!arst_n) begin
			item_valid <= 1'b0;
			item       <= '0;
		end else begin
			waiting = item_valid && !item_ready;
			if (item_valid && item_ready) begin
				if (step_coder(item, r))
					due_results.push_back(r);
				items_sent++;
			end
			if (!waiting) begin
				if (stim_q.size() != 0 && !(stim_q[0].hold && due_results.size() != 0)
						&& $urandom_range(99) >= idle_pct(1'b0)) begin
					s = stim_q.pop_front();
					item_valid <= 1'b1;
					item       <= s.it;
				end else begin
					item_valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: check each result transfer against the oldest expectation
	always @(posedge clk or negedge arst_n) begin
		result_t want;
		if (!arst_n) begin
			result_ready <= 1'b0;
		end else begin
			if (result_valid && result_ready) begin
				if (due_results.size() == 0) begin
					report($sformatf("unexpected result decoded=%h", result.decoded));
				end else begin
					want = due_results.pop_front();
					if (result.decoded !== want.decoded)
						report($sformatf("decoded %h, want %h", result.decoded, want.decoded));
					if (result.overrun_seen !== want.overrun_seen)
						report($sformatf("overrun_seen %b, want %b", result.overrun_seen,
							want.overrun_seen));
					if (result.consumed_bytes !== want.consumed_bytes)
						report($sformatf("consumed_bytes %0d, want %0d",
							result.consumed_bytes, want.consumed_bytes));
					if (result.overrun_bytes !== want.overrun_bytes)
						report($sformatf("overrun_bytes %0d, want %0d",
							result.overrun_bytes, want.overrun_bytes));
				end
			end
			result_ready <= ($urandom_range(99) >= idle_pct(1'b1));
		end
	end

	// Stimulus, reset and end of run
	initial begin
		int waited;
		// decodes straight out of reset, zero counts, ignored codes
		add_item(OP_BOOL, 8'h00, HALF_PROB, 6'd0, 1'b0);
		add_item(OP_LITERAL, 8'h00, 8'h00, 6'd0, 1'b0);
		add_item(OP_SIGNED, 8'h00, 8'h00, 6'd0, 1'b0);
		add_item(OP_SIGNED + 3'd1, 8'h00, 8'h00, 6'd0, 1'b0);
		add_item(OP_SIGNED + 3'd2, 8'h5A, 8'hA5, 6'd21, 1'b0);
		add_item(OP_LAST, 8'hFF, PROB_MAX, 6'h3F, 1'b0);
		// start on an empty queue, then with a single byte
		add_item(OP_START, 8'h00, 8'h00, 6'd0, 1'b0);
		add_item(OP_PUSH, 8'hFF, 8'h00, 6'd0, 1'b0);
		add_item(OP_START, 8'h00, 8'h00, 6'd0, 1'b1);
		add_item(OP_BOOL, 8'h00, HALF_PROB, 6'd0, 1'b0);
		// full start, probability extremes, long and clamped counts running dry
		add_item(OP_PUSH, 8'hFF, 8'h00, 6'd0, 1'b0);
		add_item(OP_PUSH, 8'h00, 8'h00, 6'd0, 1'b0);
		add_item(OP_PUSH, 8'hA5, 8'h00, 6'd0, 1'b0);
		add_item(OP_START, 8'h00, 8'h00, 6'd0, 1'b0);
		add_item(OP_BOOL, 8'h00, 8'h00, 6'd0, 1'b0);
		add_item(OP_BOOL, 8'h00, PROB_MAX, 6'd0, 1'b0);
		add_item(OP_LITERAL, 8'h00, 8'h00, 6'd32, 1'b0);
		add_item(OP_SIGNED, 8'h00, 8'h00, 6'h3F, 1'b0);
		add_item(OP_LITERAL, 8'h00, 8'h00, 6'h3F, 1'b0);
		// signed values with a live sign bit
		add_item(OP_PUSH, 8'hC3, 8'h00, 6'd0, 1'b0);
		add_item(OP_PUSH, 8'h7E, 8'h00, 6'd0, 1'b0);
		add_item(OP_START, 8'h00, 8'h00, 6'd0, 1'b0);
		add_item(OP_SIGNED, 8'h00, 8'h00, 6'd1, 1'b0);
		add_item(OP_SIGNED, 8'h00, 8'h00, 6'd5, 1'b0);
		while (n_real < ITEM_GOAL)
			add_stream();
		n_total = stim_q.size();

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		wait (stim_q.size() == 0 && !item_valid);
		waited = 0;
		while (due_results.size() != 0 && waited < DRAIN_WAIT) begin
			@(posedge clk);
			waited++;
		end
		repeat (SETTLE) @(posedge clk);
		if (due_results.size() != 0)
			report($sformatf("%0d results never arrived", due_results.size()));
		if (errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

	// Hard stop well past the slowest legal run
	initial begin
		#2000000;
		$display("FAIL");
		$finish;
	end

endmodule
